/* rtl/core/packet_deframer_crc32_macros.svh */
// ---------------------------------------------------------------------------
// packet_deframer_crc32_macros.svh
// Assertion macros shared by the deframer RTL.
// ---------------------------------------------------------------------------
`ifndef PACKET_DEFRAMER_CRC32_MACROS_SVH
`define PACKET_DEFRAMER_CRC32_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PDC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, disabled while in reset.
`define PDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

/* rtl/core/pdc_pkg.sv */
// ---------------------------------------------------------------------------
// pdc_pkg
// Types, constants and the CRC-32 byte update shared by the deframer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pdc_pkg;

    // Frame layout
    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] HDR_BYTES = 17'd7;
    localparam logic [POS_W-1:0] MIN_FRAME = 17'd11;   // magic + cmd + len + crc
    localparam logic [POS_W-1:0] POS_MAX   = 17'h1FFFF;
    localparam logic [POS_W-1:0] POS_CMD   = 17'd4;
    localparam logic [POS_W-1:0] POS_LEN_H = 17'd5;
    localparam logic [POS_W-1:0] POS_LEN_L = 17'd6;
    localparam logic [POS_W-1:0] CRC_BYTES = 17'd4;

    localparam logic [7:0] MAGIC_0 = 8'h4D;  // 'M'
    localparam logic [7:0] MAGIC_1 = 8'h41;  // 'A'
    localparam logic [7:0] MAGIC_2 = 8'h47;  // 'G'
    localparam logic [7:0] MAGIC_3 = 8'h43;  // 'C'

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Result queue
    localparam int FIFO_DEPTH = 4;

    // Result kind
    localparam logic KIND_BODY    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_HDR_SHORT  = 3'd1,
        ST_BAD_MAGIC  = 3'd2,
        ST_BODY_SHORT = 3'd3,
        ST_CRC_BAD    = 3'd4
    } status_t;

    // One result beat
    typedef struct packed {
        logic        kind;
        logic [7:0]  body_byte;
        logic [7:0]  command_code;
        logic [15:0] body_length;
        status_t     status;
        logic        run_last;
    } result_t;

    // Results produced for one input beat (0, 1 or 2)
    typedef struct packed {
        logic [1:0] cnt;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = MAGIC_0;
            2'd1:    m = MAGIC_1;
            2'd2:    m = MAGIC_2;
            default: m = MAGIC_3;
        endcase
        return m;
    endfunction

    // Eight bit-steps of the reflected CRC over one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/core/packet_deframer_crc32.sv */
// Usage:
// Input channel (in_valid/in_ready) carries one buffer byte per beat in
// data_byte, with buffer_end high on the buffer's final byte. Output channel
// (out_valid/out_ready) carries result beats: body bytes (kind 0) while the
// magic matches, and one verdict beat (kind 1) on the final byte, with the
// command, the body length and the status. run_last marks the last result
// beat caused by an input byte.
// Latency: with the queue empty, a result is offered the cycle after its
// byte is accepted; otherwise it waits behind the beats already queued.
// Throughput: one byte per cycle while in_ready is high; the output side
// delivers one result per cycle while out_ready is high, and the final byte
// of a buffer may cause two results. The parser updates position, header
// fields and the CRC of one byte per cycle, and its results wait in a small
// queue (FIFO_DEPTH entries). in_ready is high while the queue has room for
// two results, so a stalled receiver holds back the input once more than
// FIFO_DEPTH - 2 results wait. Reset empties the queue and clears the parser
// to the start of a buffer; it also returns there after every final byte.
// ---------------------------------------------------------------------------
// packet_deframer_crc32
// Length-prefixed frame parser with CRC-32 check, top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_deframer_crc32 #(
    parameter int FIFO_DEPTH = pdc_pkg::FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        buffer_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  body_byte,
    output logic [7:0]  command_code,
    output logic [15:0] body_length,
    output logic [2:0]  status,
    output logic        run_last
);

    logic             in_fire;
    pdc_pkg::push_t   push;
    pdc_pkg::result_t out_res;

    assign in_fire = in_valid && in_ready;

    // Byte parser
    pdc_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .data_byte  (data_byte),
        .buffer_end (buffer_end),
        .push       (push)
    );

    // Result queue
    pdc_out_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    // Output fields
    assign kind         = out_res.kind;
    assign body_byte    = out_res.body_byte;
    assign command_code = out_res.command_code;
    assign body_length  = out_res.body_length;
    assign status       = out_res.status;
    assign run_last     = out_res.run_last;

endmodule

/* rtl/core/pdc_parser.sv */
// ---------------------------------------------------------------------------
// pdc_parser
// Per-byte frame parser: position count, header capture, CRC, verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_deframer_crc32_macros.svh"

module pdc_parser (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic [7:0]     data_byte,
    input  logic           buffer_end,
    output pdc_pkg::push_t push
);

    logic [pdc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      magic_ok_reg, magic_ok_next;
    logic [7:0]                cmd_reg, cmd_next;
    logic [15:0]               len_reg, len_next;
    logic [31:0]               crc_reg, crc_next;
    logic [31:0]               crc_rx_reg, crc_rx_next;
    logic                      done_reg, done_next;

    logic [pdc_pkg::POS_W-1:0] body_end;
    logic                      body_out;
    pdc_pkg::status_t          verdict;
    pdc_pkg::result_t          body_res;
    pdc_pkg::result_t          verdict_res;

    assign body_end = pdc_pkg::HDR_BYTES + {1'b0, len_reg};

    // Field capture and CRC for the current byte
    always_comb
    begin
        magic_ok_next = magic_ok_reg;
        cmd_next      = cmd_reg;
        len_next      = len_reg;
        crc_next      = crc_reg;
        crc_rx_next   = crc_rx_reg;
        done_next     = done_reg;
        body_out      = 1'b0;
        if (!done_reg) begin
            if (pos_reg < body_end) begin
                crc_next = pdc_pkg::crc32_byte(crc_reg, data_byte);
                if (pos_reg < pdc_pkg::POS_CMD) begin
                    if (data_byte != pdc_pkg::magic_byte(pos_reg[1:0])) begin
                        magic_ok_next = 1'b0;
                    end
                end else if (pos_reg == pdc_pkg::POS_CMD) begin
                    cmd_next = data_byte;
                end else if (pos_reg == pdc_pkg::POS_LEN_H) begin
                    len_next = {data_byte, 8'd0};
                end else if (pos_reg == pdc_pkg::POS_LEN_L) begin
                    len_next = {len_reg[15:8], data_byte};
                end else if (magic_ok_reg) begin
                    body_out = 1'b1;
                end
            end else if (pos_reg < body_end + pdc_pkg::CRC_BYTES) begin
                crc_rx_next = {crc_rx_reg[23:0], data_byte};
                if (pos_reg == body_end + pdc_pkg::CRC_BYTES - 17'd1) begin
                    done_next = 1'b1;
                end
            end
        end
        pos_next = (pos_reg == pdc_pkg::POS_MAX) ? pos_reg : pos_reg + 17'd1;
    end

    // Verdict from the state after this byte
    always_comb
    begin
        if (pos_next < pdc_pkg::MIN_FRAME) begin
            verdict = pdc_pkg::ST_HDR_SHORT;
        end else if (!magic_ok_next) begin
            verdict = pdc_pkg::ST_BAD_MAGIC;
        end else if (!done_next) begin
            verdict = pdc_pkg::ST_BODY_SHORT;
        end else if ((crc_next ^ pdc_pkg::CRC_INIT) != crc_rx_next) begin
            verdict = pdc_pkg::ST_CRC_BAD;
        end else begin
            verdict = pdc_pkg::ST_OK;
        end
    end

    // Result beats
    always_comb
    begin
        body_res              = '0;
        body_res.kind         = pdc_pkg::KIND_BODY;
        body_res.body_byte    = data_byte;
        body_res.status       = pdc_pkg::ST_OK;
        body_res.run_last     = !buffer_end;

        verdict_res           = '0;
        verdict_res.kind      = pdc_pkg::KIND_VERDICT;
        verdict_res.status    = verdict;
        verdict_res.run_last  = 1'b1;
        if (verdict != pdc_pkg::ST_HDR_SHORT) begin
            verdict_res.command_code = cmd_next;
            verdict_res.body_length  = len_next;
        end

        push = '0;
        if (in_fire) begin
            if (body_out) begin
                push.res0 = body_res;
                push.res1 = verdict_res;
                push.cnt  = buffer_end ? 2'd2 : 2'd1;
            end else begin
                push.res0 = verdict_res;
                push.res1 = verdict_res;
                push.cnt  = buffer_end ? 2'd1 : 2'd0;
            end
        end
    end

    // Parser state; the final byte of a buffer returns it to reset values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg      <= '0;
            magic_ok_reg <= 1'b1;
            cmd_reg      <= '0;
            len_reg      <= '0;
            crc_reg      <= pdc_pkg::CRC_INIT;
            crc_rx_reg   <= '0;
            done_reg     <= 1'b0;
        end else if (in_fire) begin
            if (buffer_end) begin
                pos_reg      <= '0;
                magic_ok_reg <= 1'b1;
                cmd_reg      <= '0;
                len_reg      <= '0;
                crc_reg      <= pdc_pkg::CRC_INIT;
                crc_rx_reg   <= '0;
                done_reg     <= 1'b0;
            end else begin
                pos_reg      <= pos_next;
                magic_ok_reg <= magic_ok_next;
                cmd_reg      <= cmd_next;
                len_reg      <= len_next;
                crc_reg      <= crc_next;
                crc_rx_reg   <= crc_rx_next;
                done_reg     <= done_next;
            end
        end
    end

    // Checks
    `PDC_ASSERT_SAME(a_two_beats_order, clk, rst_n, push.cnt == 2'd2,
        push.res0.kind == pdc_pkg::KIND_BODY && push.res1.kind == pdc_pkg::KIND_VERDICT)
    `PDC_ASSERT_NEXT(a_end_clears, clk, rst_n, in_fire && buffer_end,
        pos_reg == '0 && crc_reg == pdc_pkg::CRC_INIT && !done_reg)
    `PDC_ASSERT_SAME(a_done_past_min, clk, rst_n, done_reg,
        pos_reg >= pdc_pkg::MIN_FRAME)

endmodule

/* rtl/core/pdc_out_fifo.sv */
// ---------------------------------------------------------------------------
// pdc_out_fifo
// Result queue: takes up to two beats per cycle, hands out one per cycle while out_ready is high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_deframer_crc32_macros.svh"

module pdc_out_fifo #(
    parameter int DEPTH = pdc_pkg::FIFO_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pdc_pkg::push_t   push,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output pdc_pkg::result_t out_res
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_SPACE = CNT_W'(DEPTH - 2);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

    pdc_pkg::result_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        wr_ptr_1;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    assign space     = (count_reg <= CNT_SPACE);
    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_1  = ptr_inc(wr_ptr_reg);

    // Pointer and count update
    always_comb
    begin
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        case (push.cnt)
            2'd1:    wr_ptr_next = wr_ptr_1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        count_next = count_reg + CNT_W'(push.cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DEPTH; i++) begin
            if (push.cnt != 2'd0 && PTR_W'(i) == wr_ptr_reg) begin
                entry_reg[i] <= push.res0;
            end else if (push.cnt == 2'd2 && PTR_W'(i) == wr_ptr_1) begin
                entry_reg[i] <= push.res1;
            end
        end
    end

    // Checks
    `PDC_ASSERT_SAME(a_no_overflow, clk, rst_n, push.cnt != 2'd0, count_reg <= CNT_SPACE)
    `PDC_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_FULL)
    `PDC_ASSERT_NEXT(a_count_track, clk, rst_n, 1'b1,
        count_reg == $past(count_reg) + CNT_W'($past(push.cnt)) - CNT_W'($past(pop)))

endmodule

/* sim/packet_deframer_crc32_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packet_deframer_crc32_tb
// Self-checking bench for the CRC-32 frame deframer. Buffers of bytes are
// streamed in with random gaps. A byte-level predictor in the bench computes
// the body beats and the verdict of each buffer, and every output beat is
// compared field by field with the oldest prediction. The stimulus covers
// directed corner frames, a random mix of good, corrupted, truncated and
// noise buffers, and a long output hold-off that fills the result queue.
// ---------------------------------------------------------------------------

module packet_deframer_crc32_tb;

    import pdc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 700;
    localparam int MAX_GAP       = 14;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 80;

    // Magic bytes packed first byte on top
    localparam logic [31:0] MAGIC_WORD = {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};

    typedef logic [7:0] octet_q_t[$];

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        buffer_end;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [7:0]  body_byte;
    logic [7:0]  command_code;
    logic [15:0] body_length;
    logic [2:0]  status;
    logic        run_last;

    // Predictor state, one buffer at a time
    logic [POS_W-1:0] rx_pos;
    logic             magic_ok;
    logic [7:0]       rx_cmd;
    logic [15:0]      rx_len;
    logic [31:0]      crc_acc;
    logic [31:0]      crc_trailer;
    logic             frame_done;

    result_t predicted_results[$];

    // Traffic shaping and bookkeeping
    bit tx_idle;
    bit rx_idle;
    int hold_request;
    int mismatches;
    int bytes_sent;
    int buffers_sent;
    int beats_checked;
    int verdict_count [5];

    packet_deframer_crc32 uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .buffer_end   (buffer_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .body_byte    (body_byte),
        .command_code (command_code),
        .body_length  (body_length),
        .status       (status),
        .run_last     (run_last)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // CRC-32 (reflected), one data bit folded in per step
    function automatic logic [31:0] crc32_next(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc;
        for (int k = 0; k < 8; k++)
        begin
            if (r[0] ^ b[k])
                r = (r >> 1) ^ CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    function automatic void clear_deframer_state();
        rx_pos      = '0;
        magic_ok    = 1'b1;
        rx_cmd      = 8'h00;
        rx_len      = 16'h0000;
        crc_acc     = CRC_INIT;
        crc_trailer = 32'h0;
        frame_done  = 1'b0;
    endfunction

    // Predict the beats caused by one accepted byte
    function automatic void deframe_byte(input logic [7:0] d, input logic last);
        logic [POS_W-1:0] body_end;
        logic [POS_W-1:0] size;
        logic             body_out;
        result_t          r;
        body_end = HDR_BYTES + POS_W'(rx_len);
        body_out = 1'b0;
        if (!frame_done)
        begin
            if (rx_pos < body_end)
            begin
                crc_acc = crc32_next(crc_acc, d);
                if (rx_pos < POS_CMD)
                begin
                    if (d != MAGIC_WORD[8 * (3 - int'(rx_pos[1:0])) +: 8])
                        magic_ok = 1'b0;
                end
                else if (rx_pos == POS_CMD)
                    rx_cmd = d;
                else if (rx_pos == POS_LEN_H)
                    rx_len = {d, 8'h00};
                else if (rx_pos == POS_LEN_L)
                    rx_len[7:0] = d;
                else if (magic_ok)
                    body_out = 1'b1;
            end
            else if (rx_pos < body_end + CRC_BYTES)
            begin
                crc_trailer = {crc_trailer[23:0], d};
                if (rx_pos == body_end + CRC_BYTES - 1)
                    frame_done = 1'b1;
            end
        end
        if (rx_pos != POS_MAX)
            rx_pos = rx_pos + 1'b1;

        if (body_out)
        begin
            r = '0;
            r.kind      = KIND_BODY;
            r.body_byte = d;
            r.status    = ST_OK;
            r.run_last  = !last;
            predicted_results = {predicted_results, r};
        end

        // Verdict on the final byte, then back to the start of a buffer
        if (last)
        begin
            size = rx_pos;
            r = '0;
            r.kind         = KIND_VERDICT;
            r.command_code = rx_cmd;
            r.body_length  = rx_len;
            r.run_last     = 1'b1;
            if (size < MIN_FRAME)
            begin
                r.status       = ST_HDR_SHORT;
                r.command_code = 8'h00;
                r.body_length  = 16'h0000;
            end
            else if (!magic_ok)
                r.status = ST_BAD_MAGIC;
            else if (!frame_done)
                r.status = ST_BODY_SHORT;
            else if (~crc_acc != crc_trailer)
                r.status = ST_CRC_BAD;
            else
                r.status = ST_OK;
            predicted_results = {predicted_results, r};
            clear_deframer_state();
        end
    endfunction

    // Well-formed frame: magic, command, length field, random body, CRC
    function automatic octet_q_t make_frame(input logic [7:0] cmd, input int n_body,
                                            input logic [15:0] len_field);
        octet_q_t    f;
        logic [55:0] header;
        logic [31:0] c;
        header = {MAGIC_WORD, cmd, len_field};
        for (int i = 6; i >= 0; i--)
            f = {f, header[8 * i +: 8]};
        repeat (n_body)
            f = {f, 8'($urandom)};
        c = CRC_INIT;
        foreach (f[i])
            c = crc32_next(c, f[i]);
        c = ~c;
        for (int i = 3; i >= 0; i--)
            f = {f, c[8 * i +: 8]};
        return f;
    endfunction

    // One input beat; called at a rising edge, returns at the accepting edge
    task automatic send_byte(input logic [7:0] d, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= d;
        buffer_end <= last;
        do
            @(posedge clk);
        while (!in_ready);
        deframe_byte(d, last);
        bytes_sent++;
    endtask

    task automatic send_buffer(input octet_q_t f);
        foreach (f[i])
            send_byte(f[i], i == f.size() - 1);
        buffers_sent++;
    endtask

    // Stop offering and let every predicted beat come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (predicted_results.size() != 0);
    endtask

    // Header short: a lone byte, and the smallest good frame one byte short; the full frame is sent between them
    task automatic test_short_buffers();
        octet_q_t f;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        f = {};
        f = {f, 8'hFF};
        send_buffer(f);
        f = make_frame(8'hFF, 0, 16'h0000);
        send_buffer(f);
        f = f[0:f.size() - 2];
        send_buffer(f);
        wait_drained();
    endtask

    // Largest length field with a short body; body beats still come out
    task automatic test_body_short();
        octet_q_t f;
        f = make_frame(8'h00, 0, 16'hFFFF);
        f[7]  = 8'h00;
        f[8]  = 8'hFF;
        f[9]  = 8'h00;
        f[10] = 8'hFF;
        send_buffer(f);
        wait_drained();
    endtask

    // Mixed random buffers: mostly good frames, the rest damaged or noise
    task automatic test_random_buffers();
        octet_q_t f;
        int       start;
        int       pick;
        int       n_body;
        int       idx;
        start = bytes_sent;
        while (bytes_sent - start < RANDOM_ITEMS)
        begin
            tx_idle = $urandom_range(0, 3) != 0;
            rx_idle = $urandom_range(0, 3) != 0;
            n_body  = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 300)
                                                  : $urandom_range(0, 20);
            f = make_frame(8'($urandom), n_body, 16'(n_body));
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // good frame, sometimes with trailing bytes
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 4)) f = {f, 8'($urandom)};
            end
            else if (pick < 65)
            begin
                idx = $urandom_range(7, f.size() - 1);
                f[idx] = f[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (pick < 75)
            begin
                idx = $urandom_range(0, 3);
                f[idx] = f[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
            else if (pick < 85)
                f = f[0:$urandom_range(0, f.size() - 2)];
            else if (pick < 95)
            begin
                f = {};
                repeat ($urandom_range(1, 24)) f = {f, 8'($urandom)};
            end
            else
            begin
                // length field disagrees with the body actually sent
                f = make_frame(8'($urandom), n_body, 16'($urandom_range(0, 40)));
            end
            send_buffer(f);
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // Receiver holds off while a long frame streams in
    task automatic test_output_backpressure();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        hold_request = HOLD_CYCLES;
        send_buffer(make_frame(8'h5A, 40, 16'd40));
        wait_drained();
    endtask

    // Receiver ready: random stalls per beat, plus requested long hold-offs
    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Compare each accepted beat with the oldest prediction
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_results.size() == 0)
            begin
                $error("unexpected result beat: kind %0d status %0d", kind, status);
                mismatches++;
            end
            else
            begin
                exp_r = predicted_results.pop_front();
                beats_checked++;
                if (exp_r.kind == KIND_VERDICT)
                    verdict_count[int'(exp_r.status)]++;
                if (kind !== exp_r.kind)
                begin
                    $error("kind: expected %0d, got %0d", exp_r.kind, kind);
                    mismatches++;
                end
                if (body_byte !== exp_r.body_byte)
                begin
                    $error("body_byte: expected %0h, got %0h", exp_r.body_byte, body_byte);
                    mismatches++;
                end
                if (command_code !== exp_r.command_code)
                begin
                    $error("command_code: expected %0h, got %0h",
                           exp_r.command_code, command_code);
                    mismatches++;
                end
                if (body_length !== exp_r.body_length)
                begin
                    $error("body_length: expected %0d, got %0d",
                           exp_r.body_length, body_length);
                    mismatches++;
                end
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, status);
                    mismatches++;
                end
                if (run_last !== exp_r.run_last)
                begin
                    $error("run_last: expected %0d, got %0d", exp_r.run_last, run_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d beats still expected",
                 cycles, predicted_results.size());
        $display("packet_deframer_crc32: mismatch");
        $finish;
    end

    // Test sequence
    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        data_byte  <= 8'h00;
        buffer_end <= 1'b0;
        tx_idle      = 1'b0;
        rx_idle      = 1'b0;
        hold_request = 0;
        mismatches   = 0;
        bytes_sent   = 0;
        buffers_sent = 0;
        beats_checked = 0;
        foreach (verdict_count[i])
            verdict_count[i] = 0;
        clear_deframer_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_buffers();
        test_body_short();
        test_random_buffers();
        test_output_backpressure();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d buffers, %0d bytes in, %0d result beats checked",
                 buffers_sent, bytes_sent, beats_checked);
        $display("verdicts: ok %0d, header short %0d, bad magic %0d, body short %0d, crc %0d",
                 verdict_count[ST_OK], verdict_count[ST_HDR_SHORT],
                 verdict_count[ST_BAD_MAGIC], verdict_count[ST_BODY_SHORT],
                 verdict_count[ST_CRC_BAD]);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("packet_deframer_crc32: match");
        else
            $display("packet_deframer_crc32: mismatch");
        $finish;
    end

endmodule
